@@ design/ert_pkg.sv @@
// Shared types, constants and constant tables of the rounded rectangle tessellator.
`default_nettype none

package ert_pkg;

   // Fixed point format of all coordinates: 14 fraction bits, ONE_FX is 1.0.
   localparam int COORD_FRAC_BITS = 14;
   localparam int ONE_FX          = 1 << COORD_FRAC_BITS;

   // Quarter-wave sine table geometry; the depth is a power of two.
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_LOG2        = 8;
   localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

   // Reciprocal table used for division by small divisors.
   localparam int RECIP_BITS  = 16;
   localparam int RECIP_DEPTH = 64;

   // Largest legal subdivision count per corner.
   localparam int MAX_STEPS_OK = 62;

   // Corner radius limits and the substitute radius.
   localparam int RADIUS_LO  = (ONE_FX + 99) / 100;
   localparam int RADIUS_HI  = ONE_FX * 99 / 100;
   localparam int RADIUS_DEF = (ONE_FX + 5) / 10;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_STEPS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_RADIUS_X     = 2'd0,
      CSR_RADIUS_Y     = 2'd1,
      CSR_CORNER_STEPS = 2'd2
   } csr_index_type;

   typedef logic [14:0] sine_table_type [0:SINE_TABLE_DEPTH];
   typedef logic [16:0] recip_table_type [0:RECIP_DEPTH-1];

   // Payload carried down the pipeline; each stage fills in its own fields.
   typedef struct packed {
      status_type   status;
      logic [7:0]   count;
      logic         last;
      logic         centre;
      logic [7:0]   j;
      logic [5:0]   per;
      logic [5:0]   sd;
      logic [24:0]  pq;
      logic [1:0]   q;
      logic [5:0]   k;
      logic [30:0]  ps;
      logic [30:0]  pc;
      logic [8:0]   is_idx;
      logic [5:0]   is_rem;
      logic [8:0]   ic_idx;
      logic [5:0]   ic_rem;
      logic [14:0]  vs;
      logic [14:0]  vc;
      logic [13:0]  ns;
      logic [13:0]  nc;
      logic         interp_s;
      logic         interp_c;
      logic [30:0]  nps;
      logic [30:0]  npc;
      logic [14:0]  ts;
      logic [14:0]  tc;
      logic [14:0]  mx;
      logic [14:0]  my;
      logic [15:0]  pos_x;
      logic [15:0]  pos_y;
      logic [14:0]  tex_u;
      logic [14:0]  tex_v;
   } pipe_type;

   // Quotient of two constants by restoring long division; used only to build tables.
   function automatic logic [63:0] const_quotient(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], a[i]};
         if (r >= {1'b0, b}) begin
            r    = r - {1'b0, b};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sine of 90*i/DEPTH degrees, from a Q31 series, rounded to the coordinate format.
   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      logic [63:0]    x;
      logic [63:0]    sum;
      logic [63:0]    term;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q31 * 64'(i)) >> SINE_LOG2;
         sum  = x;
         term = x;
         for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 31;
            term = (term * x) >> 31;
            term = const_quotient(term, 64'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         t[i] = 15'((sum + (64'd1 << (30 - COORD_FRAC_BITS))) >> (31 - COORD_FRAC_BITS));
      end
      return t;
   endfunction

   // Floor of 2^RECIP_BITS / d for each small divisor d.
   function automatic recip_table_type build_recip_table();
      recip_table_type t;
      t[0] = '0;
      for (int d = 1; d < RECIP_DEPTH; d++) begin
         t[d] = 17'(const_quotient(64'd1 << RECIP_BITS, 64'(d)));
      end
      return t;
   endfunction

   localparam sine_table_type  SINE_TABLE  = build_sine_table();
   localparam recip_table_type RECIP_TABLE = build_recip_table();

   // Radius register with out-of-range values replaced by the default radius.
   function automatic logic [14:0] eff_radius(input logic [14:0] r);
      if (r < 15'(RADIUS_LO) || r > 15'(RADIUS_HI)) begin
         return 15'(RADIUS_DEF);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/ert_stage.sv @@
// One pipeline register stage with valid and ready that fills bubbles.
`default_nettype none

module ert_stage #(
   parameter type payload_type = logic
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        up_valid,
   output logic             up_ready,
   input  wire payload_type up_data,
   output logic             dn_valid,
   input  wire logic        dn_ready,
   output payload_type      dn_data
);

   logic        valid_ff;
   payload_type data_ff;

   // The stage takes a new item when it is empty or its item leaves this cycle.
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= up_data;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

@@ design/elliptic_round_rect_tessellator.sv @@
// Top level of the rounded rectangle triangle fan vertex generator.
//
// The block turns a vertex index into the position and texture coordinate
// of that vertex of a fan covering a square with elliptical corners.
// Channels: req_ takes a vertex index, rsp_ returns one result item for each
// index, in order. Both use valid and ready; an item moves when both are high.
// csr_ writes the corner radii and the corner step count; it is always ready
// and should be used only while no item is in flight.
// The pipeline has nine register stages, and an accepted item passes through
// each of them in order before rsp_valid shows it. One item is accepted in
// every cycle while the receiver keeps up; the stages hold a reciprocal multiply,
// a remainder correction, a sine table read or a radius multiply each, but the
// last, which adds the corner centre, the quadrant signs and the texture coordinates.
// When the receiver stalls, each stage holds its item and the pipeline keeps
// accepting until its empty stages have filled, then req_ready falls.
// Reset empties the pipeline and sets both radii to 0.1 and the step count
// to three.
`default_nettype none

module elliptic_round_rect_tessellator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_vertex_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [14:0]      rsp_tex_u,
   output logic [14:0]      rsp_tex_v,
   output logic [7:0]       rsp_vertex_count,
   output logic             rsp_is_last,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   import ert_pkg::*;

   localparam int NUM_STAGES = 9;

   logic [14:0] radius_x_ff;
   logic [14:0] radius_y_ff;
   logic [7:0]  corner_steps_ff;

   pipe_type stage_in  [NUM_STAGES];
   pipe_type stage_out [NUM_STAGES];
   logic     stage_valid [NUM_STAGES];
   logic     stage_ready [NUM_STAGES];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_x_ff     <= 15'd1638;
         radius_y_ff     <= 15'd1638;
         corner_steps_ff <= 8'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS_X:     radius_x_ff     <= csr_wdata;
            CSR_RADIUS_Y:     radius_y_ff     <= csr_wdata;
            CSR_CORNER_STEPS: corner_steps_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Stage chain.
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      logic up_valid;
      logic dn_ready;
      if (i == 0) begin : g_first
         assign up_valid = req_valid;
      end else begin : g_mid
         assign up_valid = stage_valid[i-1];
      end
      if (i == NUM_STAGES - 1) begin : g_last
         assign dn_ready = rsp_ready;
      end else begin : g_inner
         assign dn_ready = stage_ready[i+1];
      end
      ert_stage #(.payload_type(pipe_type)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (up_valid),
         .up_ready (stage_ready[i]),
         .up_data  (stage_in[i]),
         .dn_valid (stage_valid[i]),
         .dn_ready (dn_ready),
         .dn_data  (stage_out[i])
      );
   end

   assign req_ready = stage_ready[0];

   // Decode the index and start the division by the points per quadrant.
   always_comb begin
      pipe_type   p;
      logic [7:0] s;
      logic [5:0] per;
      logic [7:0] count;
      p     = '0;
      s     = corner_steps_ff;
      per   = s[5:0] + 6'd1;
      count = {per, 2'b00} + 8'd2;
      if (s > 8'(MAX_STEPS_OK)) begin
         p.status = STATUS_STEPS;
      end else if (req_vertex_index >= count) begin
         p.status = STATUS_RANGE;
         p.count  = count;
      end else begin
         p.status = STATUS_OK;
         p.count  = count;
      end
      p.last   = (req_vertex_index == count - 8'd1);
      p.centre = (req_vertex_index == 8'd0);
      p.j      = p.last ? 8'd0 : req_vertex_index - 8'd1;
      p.per    = per;
      p.sd     = (s[5:0] == 6'd0) ? 6'd1 : s[5:0];
      p.pq     = 25'(p.j * RECIP_TABLE[per]);
      stage_in[0] = p;
   end

   // Quadrant and point within it, with one remainder correction.
   always_comb begin
      pipe_type    p;
      logic [7:0]  qe;
      logic [13:0] r;
      p  = stage_out[0];
      qe = p.pq[23:16];
      r  = 14'({6'd0, p.j} - 14'(qe * p.per));
      if (r >= 14'(p.per)) begin
         qe = qe + 8'd1;
         r  = r - 14'(p.per);
      end
      p.q = qe[1:0];
      p.k = r[5:0];
      stage_in[1] = p;
   end

   // Table positions k*DEPTH/S for sine and cosine, reciprocal multiply.
   always_comb begin
      pipe_type    p;
      logic [13:0] as;
      logic [13:0] ac;
      p    = stage_out[1];
      as   = 14'(p.k) << SINE_LOG2;
      ac   = 14'(p.sd - p.k) << SINE_LOG2;
      p.ps = 31'(as * RECIP_TABLE[p.sd]);
      p.pc = 31'(ac * RECIP_TABLE[p.sd]);
      stage_in[2] = p;
   end

   // Table index and remainder, with one correction each.
   always_comb begin
      pipe_type    p;
      logic [13:0] as;
      logic [13:0] ac;
      logic [8:0]  qs;
      logic [8:0]  qc;
      logic [13:0] rs;
      logic [13:0] rc;
      p  = stage_out[2];
      as = 14'(p.k) << SINE_LOG2;
      ac = 14'(p.sd - p.k) << SINE_LOG2;
      qs = p.ps[24:16];
      qc = p.pc[24:16];
      rs = as - 14'(qs * p.sd);
      rc = ac - 14'(qc * p.sd);
      if (rs >= 14'(p.sd)) begin
         qs = qs + 9'd1;
         rs = rs - 14'(p.sd);
      end
      if (rc >= 14'(p.sd)) begin
         qc = qc + 9'd1;
         rc = rc - 14'(p.sd);
      end
      p.is_idx = qs;
      p.is_rem = rs[5:0];
      p.ic_idx = qc;
      p.ic_rem = rc[5:0];
      stage_in[3] = p;
   end

   // Sine table reads and the interpolation numerator.
   always_comb begin
      pipe_type    p;
      logic [8:0]  ns_idx;
      logic [8:0]  nc_idx;
      logic [14:0] ds;
      logic [14:0] dc;
      p      = stage_out[3];
      ns_idx = (p.is_idx == 9'(SINE_TABLE_DEPTH)) ? p.is_idx : p.is_idx + 9'd1;
      nc_idx = (p.ic_idx == 9'(SINE_TABLE_DEPTH)) ? p.ic_idx : p.ic_idx + 9'd1;
      p.vs   = SINE_TABLE[p.is_idx];
      p.vc   = SINE_TABLE[p.ic_idx];
      ds     = SINE_TABLE[ns_idx] - p.vs;
      dc     = SINE_TABLE[nc_idx] - p.vc;
      p.ns   = 14'(ds * p.is_rem) + 14'(p.sd >> 1);
      p.nc   = 14'(dc * p.ic_rem) + 14'(p.sd >> 1);
      p.interp_s = (p.is_rem != 6'd0);
      p.interp_c = (p.ic_rem != 6'd0);
      stage_in[4] = p;
   end

   // Reciprocal multiply for the interpolation step.
   always_comb begin
      pipe_type p;
      p     = stage_out[4];
      p.nps = 31'(p.ns * RECIP_TABLE[p.sd]);
      p.npc = 31'(p.nc * RECIP_TABLE[p.sd]);
      stage_in[5] = p;
   end

   // Interpolation quotient with one correction, added to the table value.
   always_comb begin
      pipe_type    p;
      logic [13:0] qs;
      logic [13:0] qc;
      logic [13:0] rs;
      logic [13:0] rc;
      p  = stage_out[5];
      qs = p.nps[29:16];
      qc = p.npc[29:16];
      rs = p.ns - 14'(qs * p.sd);
      rc = p.nc - 14'(qc * p.sd);
      if (rs >= 14'(p.sd)) begin
         qs = qs + 14'd1;
      end
      if (rc >= 14'(p.sd)) begin
         qc = qc + 14'd1;
      end
      p.ts = p.interp_s ? p.vs + 15'(qs) : p.vs;
      p.tc = p.interp_c ? p.vc + 15'(qc) : p.vc;
      stage_in[6] = p;
   end

   // Radius times the trig magnitude, rounded half up.
   always_comb begin
      pipe_type    p;
      logic [14:0] trig_x;
      logic [14:0] trig_y;
      logic [29:0] px;
      logic [29:0] py;
      p = stage_out[6];
      if (p.q[0] == 1'b0) begin
         trig_x = p.tc;
         trig_y = p.ts;
      end else begin
         trig_x = p.ts;
         trig_y = p.tc;
      end
      px   = eff_radius(radius_x_ff) * trig_x + 30'(ONE_FX / 2);
      py   = eff_radius(radius_y_ff) * trig_y + 30'(ONE_FX / 2);
      p.mx = px[28:14];
      p.my = py[28:14];
      stage_in[7] = p;
   end

   // Corner centre plus offset, signs by quadrant, texture coordinates.
   always_comb begin
      pipe_type           p;
      logic [14:0]        mag_x;
      logic [14:0]        mag_y;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [17:0] tu;
      logic signed [17:0] tv;
      p     = stage_out[7];
      mag_x = 15'(ONE_FX) - eff_radius(radius_x_ff) + p.mx;
      mag_y = 15'(ONE_FX) - eff_radius(radius_y_ff) + p.my;
      x     = (p.q == 2'd1 || p.q == 2'd2) ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      y     = p.q[1] ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      if (p.centre) begin
         x = '0;
         y = '0;
      end
      tu = 18'sd16384 + {{2{x[15]}}, x} + 18'sd1;
      tv = 18'sd16384 - {{2{y[15]}}, y} + 18'sd1;
      if (p.status == STATUS_OK) begin
         p.pos_x = x;
         p.pos_y = y;
         p.tex_u = tu[15:1];
         p.tex_v = tv[15:1];
      end else begin
         p.pos_x = '0;
         p.pos_y = '0;
         p.tex_u = '0;
         p.tex_v = '0;
         p.last  = 1'b0;
      end
      stage_in[8] = p;
   end

   // Result channel.
   assign rsp_valid        = stage_valid[NUM_STAGES-1];
   assign rsp_pos_x        = $signed(stage_out[NUM_STAGES-1].pos_x);
   assign rsp_pos_y        = $signed(stage_out[NUM_STAGES-1].pos_y);
   assign rsp_tex_u        = stage_out[NUM_STAGES-1].tex_u;
   assign rsp_tex_v        = stage_out[NUM_STAGES-1].tex_v;
   assign rsp_vertex_count = stage_out[NUM_STAGES-1].count;
   assign rsp_is_last      = stage_out[NUM_STAGES-1].last;
   assign rsp_status       = stage_out[NUM_STAGES-1].status;

   // A step count error clears every other field of the result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_STEPS |-> rsp_vertex_count == 8'd0 && !rsp_is_last)
      else $error("step error result carries data");

   // The closing vertex repeats the first corner point, which lies at positive y.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_status == STATUS_OK && !rsp_pos_y[15])
      else $error("closing vertex malformed");

   // Texture coordinates stay within the unit range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u <= 15'(ONE_FX) && rsp_tex_v <= 15'(ONE_FX))
      else $error("texture coordinate out of range");

   // The point within a quadrant never exceeds the step count.
   assert property (@(posedge clock) disable iff (reset)
      stage_valid[1] && stage_out[1].status == STATUS_OK |-> stage_out[1].k <= stage_out[1].sd)
      else $error("point index beyond step count");

endmodule

`default_nettype wire
